// ===== rtl/leb_pkg.sv =====
// shared constants and types for the line edit buffer
`default_nettype none

package leb_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int CURSOR_W = 6;

  localparam logic [7:0] KEY_PREFIX_A = 8'd0;
  localparam logic [7:0] KEY_PREFIX_B = 8'd224;
  localparam logic [7:0] KEY_LEFT     = 8'd75;
  localparam logic [7:0] KEY_RIGHT    = 8'd77;
  localparam logic [7:0] KEY_HOME     = 8'd71;
  localparam logic [7:0] KEY_END      = 8'd79;
  localparam logic [7:0] KEY_ESC      = 8'd27;
  localparam logic [7:0] KEY_ENTER    = 8'd13;
  localparam logic [7:0] KEY_BACK     = 8'd8;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_COMMIT  = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [CURSOR_W-1:0] cursor;
    logic [7:0]          key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/line_edit_buffer.sv =====
// top level of the line edit buffer: edit control and the row of cells
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  key     | key_valid/stall    | key_code[7:0]
//  event   | event_valid/stall  | event_kind[1:0] char_out[7:0] cursor_pos[5:0]
//          |                    | line_length[5:0] last_of_run
//
// enter on a nonempty line: the key transfer, one char event per character shifted
// out of cell 0, then the commit marker; no key is taken meanwhile.
// synchronous reset clears state, cursor, length, remain, the prefix flag and
// event_valid; the cells and the event payload hold no reset value. a stall on event
// holds the output register and stalls key when it cannot be freed in the same cycle.
`default_nettype none

module line_edit_buffer import leb_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                key_valid,
  output logic                     key_stall,
  input  wire logic [7:0]          key_code,
  output logic                     event_valid,
  input  wire logic                event_stall,
  output logic [1:0]               event_kind,
  output logic [7:0]               char_out,
  output logic [CURSOR_W-1:0]      cursor_pos,
  output logic [CURSOR_W-1:0]      line_length,
  output logic                     last_of_run
);

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(LINE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_EDIT = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] cursor, cursor_next;
  logic [IDX_W-1:0] length, length_next;
  logic [IDX_W-1:0] remain, remain_next;
  logic             prefix, prefix_next;

  logic             out_free;
  logic             accept;
  logic             load;
  logic [1:0]       kind_load;
  logic [7:0]       char_load;
  logic             last_load;
  cell_ctrl_t       ctrl;

  logic [7:0] cell_data [LINE_DEPTH];

  assign out_free  = !event_valid || !event_stall;
  assign key_stall = (state != ST_EDIT) || !out_free;
  assign accept    = key_valid && !key_stall;

  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    length_next = length;
    remain_next = remain;
    prefix_next = prefix;
    load        = 1'b0;
    kind_load   = KIND_STATUS;
    char_load   = 8'h00;
    last_load   = 1'b1;
    ctrl.op     = CELL_HOLD;
    ctrl.cursor = CURSOR_W'(cursor);
    ctrl.key    = key_code;

    case (state)
      ST_EDIT: begin
        if (accept) begin
          load = 1'b1;
          if (prefix) begin
            prefix_next = 1'b0;
            case (key_code)
              KEY_LEFT: begin
                if (cursor != '0) cursor_next = cursor - 1'b1;
              end
              KEY_RIGHT: begin
                if (cursor < length) cursor_next = cursor + 1'b1;
              end
              KEY_HOME: cursor_next = '0;
              KEY_END:  cursor_next = length;
              default:  cursor_next = cursor;
            endcase
          end else if (key_code inside {KEY_PREFIX_A, KEY_PREFIX_B}) begin
            prefix_next = 1'b1;
          end else if (key_code == KEY_ESC) begin
            cursor_next = '0;
            length_next = '0;
            kind_load   = KIND_DISCARD;
          end else if (key_code == KEY_ENTER) begin
            cursor_next = '0;
            length_next = '0;
            kind_load   = KIND_COMMIT;
            if (length != '0) begin
              // characters go out first, the marker follows from the emit state
              load        = 1'b0;
              remain_next = length;
              state_next  = ST_EMIT;
            end
          end else if (key_code == KEY_BACK) begin
            if (cursor != '0) begin
              ctrl.op     = CELL_DELETE;
              cursor_next = cursor - 1'b1;
              length_next = length - 1'b1;
            end
          end else begin
            if (length != LEN_MAX) begin
              ctrl.op     = CELL_INSERT;
              cursor_next = cursor + 1'b1;
              length_next = length + 1'b1;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (remain != '0) begin
            ctrl.op     = CELL_SHIFT;
            kind_load   = KIND_CHAR;
            char_load   = cell_data[0];
            last_load   = 1'b0;
            remain_next = remain - 1'b1;
          end else begin
            kind_load  = KIND_COMMIT;
            state_next = ST_EDIT;
          end
        end
      end
      default: begin
        state_next = ST_EDIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_EDIT;
      cursor      <= '0;
      length      <= '0;
      remain      <= '0;
      prefix      <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      state       <= state_next;
      cursor      <= cursor_next;
      length      <= length_next;
      remain      <= remain_next;
      prefix      <= prefix_next;
      event_valid <= load || (event_valid && event_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind  <= kind_load;
      char_out    <= char_load;
      cursor_pos  <= CURSOR_W'(cursor_next);
      line_length <= CURSOR_W'(length_next);
      last_of_run <= last_load;
    end
  end

  for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
    logic [7:0] left_in;
    logic [7:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = 8'h00;
    end else begin : g_left
      assign left_in = cell_data[i-1];
    end

    if (i == LINE_DEPTH - 1) begin : g_last
      assign right_in = 8'h00;
    end else begin : g_right
      assign right_in = cell_data[i+1];
    end

    leb_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_data (left_in),
      .right_data(right_in),
      .data      (cell_data[i])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/leb_cell.sv =====
// one character cell of the line buffer row
`default_nettype none

module leb_cell import leb_pkg::*; #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic [7:0] left_data,
  input  wire logic [7:0] right_data,
  output logic      [7:0] data
);

  localparam logic [CURSOR_W:0] IDX = (CURSOR_W + 1)'(CELL_INDEX);

  logic [CURSOR_W:0] cur;

  assign cur = {1'b0, ctrl.cursor};

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (IDX > cur) begin
          data <= left_data;
        end else if (IDX == cur) begin
          data <= ctrl.key;
        end
      end
      // cursor is nonzero here, so this is index >= cursor - 1
      CELL_DELETE: begin
        if (IDX + 1'b1 >= cur) begin
          data <= right_data;
        end
      end
      CELL_SHIFT: begin
        data <= right_data;
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

`default_nettype wire
